// ===== design/cbgi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_pkg
// Types and constants shared by the clamped bilinear grid interpolator.
// ----------------------------------------------------------------------------
package cbgi_pkg;

	localparam int VAL_W        = 32;
	localparam int WEIGHT_FRAC  = 16;
	localparam int WEIGHT_W     = WEIGHT_FRAC + 1;
	localparam int TIME_COUNT_W = 5;
	localparam int SPOT_COUNT_W = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;
	localparam int MIN_COUNT    = 2;

	// Store depths; the count registers and the 10-bit entry index are sized
	// for exactly these.
	localparam int MAX_TIMES    = 16;
	localparam int MAX_SPOTS    = 64;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPOT_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_TIME_KNOT = 2'd0,
		OP_SPOT_KNOT = 2'd1,
		OP_GRID      = 2'd2,
		OP_QUERY     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		BLEND_ROW0 = 2'd0,
		BLEND_ROW1 = 2'd1,
		BLEND_TIME = 2'd2
	} blend_t;

	typedef struct packed {
		logic       accept;
		logic       ends_hi;
		logic       ends_cap;
		logic       scan;
		logic       brk;
		logic       knot_lo;
		logic       knot_hi;
		logic       knot_cap;
		logic       wset;
		logic       wdiv;
		logic       axis;
		logic [4:0] grid;
		logic       mul;
		logic       add;
		blend_t     blend_sel;
		logic       out_load;
	} cbgi_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_skip;
		logic div_last;
		logic out_free;
	} cbgi_status_t;

endpackage
`default_nettype wire

// ===== design/cbgi_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_req_if
// Request channel: table writes and queries.
// ----------------------------------------------------------------------------
interface cbgi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [9:0]  entry_index;
	logic [31:0] entry_value;
	logic [31:0] query_time;
	logic [31:0] query_spot;

	modport source (output valid, opcode, entry_index, entry_value, query_time, query_spot,
		input ready);
	modport sink (input valid, opcode, entry_index, entry_value, query_time, query_spot,
		output ready);
endinterface
`default_nettype wire

// ===== design/cbgi_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_rsp_if
// Response channel: one interpolated value per query.
// ----------------------------------------------------------------------------
interface cbgi_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] volatility;

	modport source (output valid, volatility, input ready);
	modport sink (input valid, volatility, output ready);
endinterface
`default_nettype wire

// ===== design/cbgi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbgi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/cbgi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_ctrl
// Query sequencer: steps the datapath through clamp, search, weights, blend.
// ----------------------------------------------------------------------------
module cbgi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_query,
	input  cbgi_pkg::cbgi_status_t status,
	output cbgi_pkg::cbgi_cmd_t    cmd
);
	import cbgi_pkg::*;

	typedef enum logic [20:0] {
		ST_IDLE  = 21'h000001,
		ST_ENDS0 = 21'h000002,
		ST_ENDS1 = 21'h000004,
		ST_ENDS2 = 21'h000008,
		ST_SCAN  = 21'h000010,
		ST_BRK   = 21'h000020,
		ST_KNOT0 = 21'h000040,
		ST_KNOT1 = 21'h000080,
		ST_KNOT2 = 21'h000100,
		ST_WSET  = 21'h000200,
		ST_WDIV  = 21'h000400,
		ST_G0    = 21'h000800,
		ST_G1    = 21'h001000,
		ST_G2    = 21'h002000,
		ST_G3    = 21'h004000,
		ST_G4    = 21'h008000,
		ST_MUL   = 21'h010000,
		ST_ADD   = 21'h020000,
		ST_OUT   = 21'h040000
	} state_t;

	state_t state_q, state_d;
	logic   axis_q, axis_d;
	blend_t blend_q, blend_d;

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		blend_d = blend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req_query) begin
					state_d = ST_ENDS0;
				end
			end
			ST_ENDS0: state_d = ST_ENDS1;
			ST_ENDS1: state_d = ST_ENDS2;
			ST_ENDS2: state_d = ST_SCAN;
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_BRK;
				end
			end
			ST_BRK:   state_d = ST_KNOT0;
			ST_KNOT0: state_d = ST_KNOT1;
			ST_KNOT1: state_d = ST_KNOT2;
			ST_KNOT2: begin
				state_d = ST_WSET;
				axis_d  = 1'b0;
			end
			ST_WSET, ST_WDIV: begin
				if ((state_q == ST_WSET) && !status.div_skip) begin
					state_d = ST_WDIV;
				end else if ((state_q == ST_WSET) || status.div_last) begin
					if (axis_q) begin
						state_d = ST_G0;
					end else begin
						state_d = ST_WSET;
						axis_d  = 1'b1;
					end
				end
			end
			ST_G0: state_d = ST_G1;
			ST_G1: state_d = ST_G2;
			ST_G2: state_d = ST_G3;
			ST_G3: state_d = ST_G4;
			ST_G4: begin
				state_d = ST_MUL;
				blend_d = BLEND_ROW0;
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: begin
				unique case (blend_q)
					BLEND_ROW0: begin
						blend_d = BLEND_ROW1;
						state_d = ST_MUL;
					end
					BLEND_ROW1: begin
						blend_d = BLEND_TIME;
						state_d = ST_MUL;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			blend_q <= BLEND_ROW0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			blend_q <= blend_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.blend_sel = blend_q;
		cmd.accept    = (state_q == ST_IDLE);
		cmd.ends_hi   = (state_q == ST_ENDS1);
		cmd.ends_cap  = (state_q == ST_ENDS2);
		cmd.scan      = (state_q == ST_SCAN);
		cmd.brk       = (state_q == ST_BRK);
		cmd.knot_lo   = (state_q == ST_KNOT0);
		cmd.knot_hi   = (state_q == ST_KNOT1);
		cmd.knot_cap  = (state_q == ST_KNOT2);
		cmd.wset      = (state_q == ST_WSET);
		cmd.wdiv      = (state_q == ST_WDIV);
		cmd.grid      = {state_q == ST_G4, state_q == ST_G3, state_q == ST_G2,
			state_q == ST_G1, state_q == ST_G0};
		cmd.mul       = (state_q == ST_MUL);
		cmd.add       = (state_q == ST_ADD);
		cmd.out_load  = (state_q == ST_OUT) && status.out_free;
	end
endmodule
`default_nettype wire

// ===== design/cbgi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbgi_dp
// Datapath: knot and grid stores, bracket scan, weight divider, blend unit.
// ----------------------------------------------------------------------------
module cbgi_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbgi_pkg::cbgi_cmd_t                  cmd,
	output cbgi_pkg::cbgi_status_t               status,
	input  logic                                 cfg_we,
	input  logic [cbgi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cbgi_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 req_valid,
	input  logic [1:0]                           opcode,
	input  logic [9:0]                           entry_index,
	input  logic [31:0]                          entry_value,
	input  logic [31:0]                          query_time,
	input  logic [31:0]                          query_spot,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [31:0]                          volatility
);
	import cbgi_pkg::*;

	localparam int TAW   = $clog2(MAX_TIMES);
	localparam int SAW   = $clog2(MAX_SPOTS);
	localparam int GDEPTH = MAX_TIMES * MAX_SPOTS;
	localparam int GAW   = $clog2(GDEPTH);
	localparam int NTW   = $clog2(MAX_TIMES + 1);
	localparam int NSW   = $clog2(MAX_SPOTS + 1);
	localparam int MAXN  = (MAX_TIMES > MAX_SPOTS) ? MAX_TIMES : MAX_SPOTS;
	localparam int CW    = $clog2(MAXN + 1);
	localparam int DCW   = $clog2(WEIGHT_FRAC);

	function automatic logic [VAL_W-1:0] clamp_span(input logic [VAL_W-1:0] v,
		input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
		logic [VAL_W-1:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	logic [TIME_COUNT_W-1:0] time_count_q;
	logic [SPOT_COUNT_W-1:0] spot_count_q;
	logic [NTW-1:0]          nt;
	logic [NSW-1:0]          ns;
	logic [CW-1:0]           maxn;
	logic                    accept;

	logic [TAW-1:0]   t_raddr;
	logic [SAW-1:0]   s_raddr;
	logic [GAW-1:0]   g_raddr;
	logic [VAL_W-1:0] t_rdata, s_rdata, g_rdata;
	logic             t_we, s_we, g_we;

	logic [VAL_W-1:0] qt_q, qs_q, tc_q, sc_q;
	logic [VAL_W-1:0] lo_t_q, hi_t_q, lo_s_q, hi_s_q;
	logic [CW-1:0]    cnt_q;
	logic             found_t_q, found_s_q;
	logic [TAW-1:0]   br_t_q, it_q;
	logic [SAW-1:0]   br_s_q, is_q;
	logic [GAW-1:0]   r0_q;

	logic [VAL_W-1:0]    wx, wk0, wk1;
	logic [VAL_W:0]      num, den, num_neg, den_neg;
	logic [VAL_W-1:0]    an, ad;
	logic                w_zero, w_full;
	logic [VAL_W:0]      rem_q;
	logic [VAL_W-1:0]    dden_q;
	logic [WEIGHT_FRAC-1:0] quot_q, quot_next;
	logic [DCW-1:0]      dcnt_q;
	logic [VAL_W+1:0]    rem2;
	logic                rem_ge;
	logic [WEIGHT_W-1:0] wt_q, ws_q, w_new;
	logic                w_we;

	logic [VAL_W-1:0] g00_q, g01_q, g10_q, g11_q, v0_q, v1_q, res_q;
	logic [VAL_W-1:0] ba, bb;
	logic [WEIGHT_W-1:0] bw;
	logic signed [VAL_W:0]         bdiff;
	logic signed [VAL_W+WEIGHT_W+1:0] prod_q, bsum;
	logic             rsp_valid_q;

	// Counts outside the supported span are pinned to it.
	always_comb begin
		if (32'(time_count_q) < MIN_COUNT) nt = NTW'(MIN_COUNT);
		else if (32'(time_count_q) > MAX_TIMES) nt = NTW'(MAX_TIMES);
		else nt = NTW'(time_count_q);
		if (32'(spot_count_q) < MIN_COUNT) ns = NSW'(MIN_COUNT);
		else if (32'(spot_count_q) > MAX_SPOTS) ns = NSW'(MAX_SPOTS);
		else ns = NSW'(spot_count_q);
		maxn = (32'(nt) > 32'(ns)) ? CW'(nt) : CW'(ns);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_count_q <= TIME_COUNT_W'(MIN_COUNT);
			spot_count_q <= SPOT_COUNT_W'(MIN_COUNT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIME_COUNT: time_count_q <= cfg_data[TIME_COUNT_W-1:0];
				CFG_SPOT_COUNT: spot_count_q <= cfg_data[SPOT_COUNT_W-1:0];
			endcase
		end
	end

	assign accept = cmd.accept && req_valid;
	assign t_we = accept && (opcode == OP_TIME_KNOT) && (32'(entry_index) < MAX_TIMES);
	assign s_we = accept && (opcode == OP_SPOT_KNOT) && (32'(entry_index) < MAX_SPOTS);
	assign g_we = accept && (opcode == OP_GRID) && (32'(entry_index) < GDEPTH);

	always_comb begin
		t_raddr = '0;
		s_raddr = '0;
		priority if (cmd.ends_hi) begin
			t_raddr = TAW'(nt - NTW'(1));
			s_raddr = SAW'(ns - NSW'(1));
		end else if (cmd.scan) begin
			t_raddr = cnt_q[TAW-1:0];
			s_raddr = cnt_q[SAW-1:0];
		end else if (cmd.knot_lo) begin
			t_raddr = it_q;
			s_raddr = is_q;
		end else if (cmd.knot_hi) begin
			t_raddr = it_q + TAW'(1);
			s_raddr = is_q + SAW'(1);
		end
	end

	always_comb begin
		g_raddr = r0_q;
		priority if (cmd.grid[1]) g_raddr = r0_q + GAW'(1);
		else if (cmd.grid[2]) g_raddr = r0_q + GAW'(ns);
		else if (cmd.grid[3]) g_raddr = r0_q + GAW'(ns) + GAW'(1);
	end

	cbgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_TIMES)) u_time_ram (
		.clk(clk), .we(t_we), .waddr(TAW'(entry_index)), .wdata(entry_value),
		.raddr(t_raddr), .rdata(t_rdata));
	cbgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SPOTS)) u_spot_ram (
		.clk(clk), .we(s_we), .waddr(SAW'(entry_index)), .wdata(entry_value),
		.raddr(s_raddr), .rdata(s_rdata));
	cbgi_ram #(.WIDTH(VAL_W), .DEPTH(GDEPTH)) u_grid_ram (
		.clk(clk), .we(g_we), .waddr(GAW'(entry_index)), .wdata(entry_value),
		.raddr(g_raddr), .rdata(g_rdata));

	assign status.scan_done = (cnt_q == maxn);

	// Clamp, linear bracket scan and corner knot fetch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			found_t_q <= 1'b0;
			found_s_q <= 1'b0;
		end else begin
			if (cmd.ends_cap) begin
				cnt_q     <= CW'(1);
				found_t_q <= 1'b0;
				found_s_q <= 1'b0;
			end else if (cmd.scan) begin
				if (cnt_q != maxn) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if ((cnt_q >= CW'(2)) && (32'(cnt_q) <= 32'(nt)) && !found_t_q &&
					(t_rdata >= tc_q)) begin
					found_t_q <= 1'b1;
				end
				if ((cnt_q >= CW'(2)) && (32'(cnt_q) <= 32'(ns)) && !found_s_q &&
					(s_rdata >= sc_q)) begin
					found_s_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qt_q <= query_time;
			qs_q <= query_spot;
		end
		if (cmd.ends_hi || cmd.knot_hi) begin
			lo_t_q <= t_rdata;
			lo_s_q <= s_rdata;
		end
		if (cmd.ends_cap || cmd.knot_cap) begin
			hi_t_q <= t_rdata;
			hi_s_q <= s_rdata;
		end
		if (cmd.ends_cap) begin
			tc_q <= clamp_span(qt_q, lo_t_q, t_rdata);
			sc_q <= clamp_span(qs_q, lo_s_q, s_rdata);
		end
		if (cmd.scan && (cnt_q >= CW'(2))) begin
			if ((32'(cnt_q) <= 32'(nt)) && !found_t_q && (t_rdata >= tc_q)) begin
				br_t_q <= TAW'(cnt_q - CW'(2));
			end
			if ((32'(cnt_q) <= 32'(ns)) && !found_s_q && (s_rdata >= sc_q)) begin
				br_s_q <= SAW'(cnt_q - CW'(2));
			end
		end
		if (cmd.brk) begin
			if (tc_q <= lo_t_q) it_q <= '0;
			else if (tc_q >= hi_t_q) it_q <= TAW'(nt - NTW'(MIN_COUNT));
			else it_q <= br_t_q;
			if (sc_q <= lo_s_q) is_q <= '0;
			else if (sc_q >= hi_s_q) is_q <= SAW'(ns - NSW'(MIN_COUNT));
			else is_q <= br_s_q;
		end
		if (cmd.knot_lo) begin
			r0_q <= GAW'(it_q) * GAW'(ns) + GAW'(is_q);
		end
	end

	// Weight = (x - k0) / (k1 - k0) in Q1.16, one quotient bit per cycle.
	always_comb begin
		wx  = cmd.axis ? sc_q : tc_q;
		wk0 = cmd.axis ? lo_s_q : lo_t_q;
		wk1 = cmd.axis ? hi_s_q : hi_t_q;
		num = {1'b0, wx} - {1'b0, wk0};
		den = {1'b0, wk1} - {1'b0, wk0};
		num_neg = ~num + (VAL_W+1)'(1);
		den_neg = ~den + (VAL_W+1)'(1);
		an = num[VAL_W] ? num_neg[VAL_W-1:0] : num[VAL_W-1:0];
		ad = den[VAL_W] ? den_neg[VAL_W-1:0] : den[VAL_W-1:0];
		w_zero = (wk1 == wk0) || (num == '0) || (num[VAL_W] != den[VAL_W]);
		w_full = (an >= ad);
		rem2   = {rem_q, 1'b0};
		rem_ge = (rem2 >= {2'b00, dden_q});
		quot_next = {quot_q[WEIGHT_FRAC-2:0], rem_ge};
	end

	assign status.div_skip = w_zero || w_full;
	assign status.div_last = (dcnt_q == DCW'(WEIGHT_FRAC - 1));

	always_comb begin
		w_we  = 1'b0;
		w_new = '0;
		if (cmd.wset && w_zero) begin
			w_we = 1'b1;
		end else if (cmd.wset && w_full) begin
			w_we  = 1'b1;
			w_new = WEIGHT_ONE;
		end else if (cmd.wdiv && status.div_last) begin
			w_we  = 1'b1;
			w_new = {1'b0, quot_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.wset) begin
			dcnt_q <= '0;
		end else if (cmd.wdiv) begin
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wset) begin
			rem_q  <= {1'b0, an};
			dden_q <= ad;
			quot_q <= '0;
		end else if (cmd.wdiv) begin
			rem_q  <= rem_ge ? (VAL_W+1)'(rem2 - {2'b00, dden_q}) : rem2[VAL_W:0];
			quot_q <= quot_next;
		end
		if (w_we) begin
			if (cmd.axis) ws_q <= w_new;
			else wt_q <= w_new;
		end
	end

	// Blend a + floor(w * (b - a) / 2^16), equal to ((1 - w) * a + w * b) >> 16.
	always_comb begin
		unique case (cmd.blend_sel)
			BLEND_ROW0: begin
				ba = g00_q;
				bb = g01_q;
				bw = ws_q;
			end
			BLEND_ROW1: begin
				ba = g10_q;
				bb = g11_q;
				bw = ws_q;
			end
			default: begin
				ba = v0_q;
				bb = v1_q;
				bw = wt_q;
			end
		endcase
		bdiff = $signed({1'b0, bb}) - $signed({1'b0, ba});
		bsum  = $signed({{(WEIGHT_W+2){1'b0}}, ba}) + (prod_q >>> WEIGHT_FRAC);
	end

	always_ff @(posedge clk) begin
		if (cmd.grid[1]) g00_q <= g_rdata;
		if (cmd.grid[2]) g01_q <= g_rdata;
		if (cmd.grid[3]) g10_q <= g_rdata;
		if (cmd.grid[4]) g11_q <= g_rdata;
		if (cmd.mul) begin
			prod_q <= (VAL_W+WEIGHT_W+2)'(bdiff * $signed({1'b0, bw}));
		end
		if (cmd.add) begin
			unique case (cmd.blend_sel)
				BLEND_ROW0: v0_q <= bsum[VAL_W-1:0];
				BLEND_ROW1: v1_q <= bsum[VAL_W-1:0];
				default:    res_q <= bsum[VAL_W-1:0];
			endcase
		end
		if (cmd.out_load) begin
			volatility <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status.out_free = !rsp_valid_q || rsp_ready;
endmodule
`default_nettype wire

// ===== design/clamped_bilinear_grid_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_bilinear_grid_interpolator
// Bilinear lookup on a rectilinear time by spot grid with clamped queries.
// ----------------------------------------------------------------------------
// Channel  Dir  Word contents
// req      in   opcode, entry_index, entry_value, query_time, query_spot
// rsp      out  volatility (one word per query)
// cfg      in   cfg_we, cfg_index, cfg_data (time_count, spot_count)
//
// A write word (time knot, spot knot or grid value) is taken while the block
// sits idle and leaves it idle, so ready stays high for the next word.
// A query holds ready low from its accepting edge until its result is loaded
// into the output register. The bracket search reads one knot per cycle from
// each knot RAM, up to the larger of the two counts after pinning to their
// spans, and each weight comes from a 16-step restoring divider that the two
// axes share. A weight of zero or one skips its divider.
// Reset clears the sequencer and sets both counts to two; the RAM contents are
// not cleared and must be written before they are queried.
// A finished result sits in the output register; a stalled rsp holds the
// sequencer in its last state while write words wait for the next idle cycle.
// ----------------------------------------------------------------------------
module clamped_bilinear_grid_interpolator (
	input  logic                            clk,
	input  logic                            arst_n,
	cbgi_req_if.sink                        req,
	cbgi_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [cbgi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbgi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cbgi_pkg::*;

	cbgi_cmd_t    cmd;
	cbgi_status_t status;

	// The sequencer owns all timing; the datapath only reacts to commands.
	cbgi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_query (req.opcode == OP_QUERY),
		.status    (status),
		.cmd       (cmd)
	);

	cbgi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req.valid),
		.opcode      (req.opcode),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.query_time  (req.query_time),
		.query_spot  (req.query_spot),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.volatility  (rsp.volatility)
	);

	// The request side is ready exactly when the sequencer sits idle.
	assign req.ready = cmd.accept;

	// A write word never starts query work.
	a_write_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.opcode != OP_QUERY)) |=> req.ready)
		else $error("write word left the block busy");

	// A query word always takes the block out of idle.
	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.opcode == OP_QUERY)) |=> !req.ready)
		else $error("query word did not start work");

	// A new result only appears at the end of query work.
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> !$past(req.ready))
		else $error("result appeared while idle");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clamped bilinear grid interpolator. Every knot
// and grid entry is filled first, then directed and random words with random
// idling on both channels are sent. Each accepted query is predicted by the
// scoreboard, and each returned volatility is checked against it.
// ----------------------------------------------------------------------------
module testbench;
	import cbgi_pkg::*;

	localparam int TIME_DEPTH = 16;
	localparam int SPOT_DEPTH = 64;
	localparam int GRID_DEPTH = TIME_DEPTH * SPOT_DEPTH;
	localparam int SETTLE_CYCLES = 140;

	// Mirror of the block's tables and counts, plus the queue of pending
	// volatility values. Only accepted words reach it.
	class vol_scoreboard;
		bit [31:0] tknot[TIME_DEPTH];
		bit [31:0] sknot[SPOT_DEPTH];
		bit [31:0] grid[GRID_DEPTH];
		bit [4:0] tcount = 5'd2;
		bit [6:0] scount = 7'd2;
		bit [31:0] pending_vol[$];
		int mismatches = 0;
		int checked = 0;

		function int used_count(int raw, int most);
			if (raw < MIN_COUNT) return MIN_COUNT;
			if (raw > most) return most;
			return raw;
		endfunction

		function int bracket(bit axis, int n, bit [31:0] v);
			int i;
			bit [31:0] k0, kl;
			k0 = axis ? sknot[0] : tknot[0];
			kl = axis ? sknot[n-1] : tknot[n-1];
			if (v <= k0) return 0;
			if (v >= kl) return n - 2;
			for (i = 0; i < n; i++) begin
				if ((axis ? sknot[i] : tknot[i]) >= v) break;
			end
			i = i - 1;
			if (i > n - 2) i = n - 2;
			return i;
		endfunction

		function bit [16:0] weight(bit [31:0] x, bit [31:0] k0, bit [31:0] k1);
			longint num, den, an, ad;
			if (k1 == k0) return 17'd0;
			num = longint'({32'd0, x}) - longint'({32'd0, k0});
			den = longint'({32'd0, k1}) - longint'({32'd0, k0});
			if (num == 0) return 17'd0;
			if ((num < 0) != (den < 0)) return 17'd0;
			an = num < 0 ? -num : num;
			ad = den < 0 ? -den : den;
			if (an >= ad) return WEIGHT_ONE;
			return 17'((an << 16) / ad);
		endfunction

		function bit [31:0] blend(bit [31:0] a, bit [31:0] b, bit [16:0] w);
			bit [63:0] s;
			s = 64'(WEIGHT_ONE - w) * 64'(a) + 64'(w) * 64'(b);
			return s[47:16];
		endfunction

		function void set_count(bit idx, bit [6:0] data);
			if (idx == CFG_TIME_COUNT) tcount = data[4:0];
			else scount = data;
		endfunction

		// Applies one accepted request word; a query queues its volatility.
		function void note_word(opcode_t op, bit [9:0] idx, bit [31:0] val,
				bit [31:0] qt, bit [31:0] qs);
			int nt, ns, it, is, r0, r1;
			bit [31:0] tc, sc, v0, v1;
			bit [16:0] wt, ws;
			case (op)
				OP_TIME_KNOT: if (idx < TIME_DEPTH) tknot[idx] = val;
				OP_SPOT_KNOT: if (idx < SPOT_DEPTH) sknot[idx] = val;
				OP_GRID:      grid[idx] = val;
				default: begin
					nt = used_count(tcount, TIME_DEPTH);
					ns = used_count(scount, SPOT_DEPTH);
					// Below the first knot wins over above the last one.
					tc = qt < tknot[0] ? tknot[0] : (qt > tknot[nt-1] ? tknot[nt-1] : qt);
					sc = qs < sknot[0] ? sknot[0] : (qs > sknot[ns-1] ? sknot[ns-1] : qs);
					it = bracket(1'b0, nt, tc);
					is = bracket(1'b1, ns, sc);
					wt = weight(tc, tknot[it], tknot[it+1]);
					ws = weight(sc, sknot[is], sknot[is+1]);
					r0 = it * ns + is;
					r1 = (it + 1) * ns + is;
					v0 = blend(grid[r0], grid[r0+1], ws);
					v1 = blend(grid[r1], grid[r1+1], ws);
					pending_vol.push_back(blend(v0, v1, wt));
				end
			endcase
		endfunction

		function void check_vol(bit [31:0] got);
			bit [31:0] want;
			checked++;
			if (pending_vol.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: volatility %h returned with no query pending", got);
				return;
			end
			want = pending_vol.pop_front();
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: volatility expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	bit calm = 1'b0;
	int stall_left = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_settings = 0;

	vol_scoreboard sb = new();

	cbgi_req_if req_ch();
	cbgi_rsp_if rsp_ch();

	clamped_bilinear_grid_interpolator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one; none in calm phases.
	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The response side stalls on its own schedule, changing at the falling edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready = 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready = 1'b1;
			stall_left = idle_len();
		end
	end

	// A volatility word counts when valid and ready are both high at the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_vol(rsp_ch.volatility);
	end

	// Sends one request word. It is entered and left at a falling edge, and
	// valid stays high when the next word follows without a gap.
	task automatic send_word(opcode_t op, bit [9:0] idx, bit [31:0] val,
			bit [31:0] qt, bit [31:0] qs);
		int gap;
		req_ch.opcode = op;
		req_ch.entry_index = idx;
		req_ch.entry_value = val;
		req_ch.query_time = qt;
		req_ch.query_spot = qs;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_word(op, idx, val, qt, qs);
		if (op == OP_QUERY) n_queries++;
		else n_writes++;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic query(bit [31:0] qt, bit [31:0] qs);
		send_word(OP_QUERY, $urandom(), $urandom(), qt, qs);
	endtask

	task automatic write_entry(opcode_t op, bit [9:0] idx, bit [31:0] val);
		send_word(op, idx, val, $urandom(), $urandom());
	endtask

	// Registers change only with nothing in flight. A write word cannot be
	// seen to finish, so the settle time after the last result covers the
	// longest query the block could still be working on.
	task automatic set_counts(bit [6:0] tdata, bit [6:0] sdata);
		req_ch.valid = 1'b0;
		wait (sb.pending_vol.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_TIME_COUNT;
		cfg_data = tdata;
		@(negedge clk);
		cfg_index = CFG_SPOT_COUNT;
		cfg_data = sdata;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_count(CFG_TIME_COUNT, tdata);
		sb.set_count(CFG_SPOT_COUNT, sdata);
		n_settings++;
	endtask

	// Lays down ascending knots with random steps. Roughly one step in eight
	// is zero, which gives equal neighbors and a zero weight.
	task automatic lay_knots();
		bit [31:0] k;
		k = $urandom_range(0, 1 << 20);
		for (int i = 0; i < TIME_DEPTH; i++) begin
			write_entry(OP_TIME_KNOT, i, k);
			k += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 26);
		end
		k = $urandom_range(0, 1 << 20);
		for (int i = 0; i < SPOT_DEPTH; i++) begin
			write_entry(OP_SPOT_KNOT, i, k);
			k += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 25);
		end
	endtask

	// A coordinate for one axis: mostly inside the active span, sometimes
	// exactly on a knot, sometimes anywhere in the 32-bit range.
	function automatic bit [31:0] pick_coord(bit axis);
		int n, r;
		bit [31:0] lo, hi;
		n = axis ? sb.used_count(sb.scount, SPOT_DEPTH) : sb.used_count(sb.tcount, TIME_DEPTH);
		lo = axis ? sb.sknot[0] : sb.tknot[0];
		hi = axis ? sb.sknot[n-1] : sb.tknot[n-1];
		r = $urandom_range(0, 9);
		if (r < 2) return $urandom();
		if (r < 4) return axis ? sb.sknot[$urandom_range(0, n-1)] : sb.tknot[$urandom_range(0, n-1)];
		if (hi > lo) return lo + $urandom_range(0, hi - lo);
		return lo + $urandom_range(0, 3) - 1;
	endfunction

	initial begin
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_TIME_KNOT;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		req_ch.query_time = '0;
		req_ch.query_spot = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every table entry so that no query can ever read an unwritten
		// one, whatever counts come later. Grid values span all 32 bits.
		lay_knots();
		for (int i = 0; i < GRID_DEPTH; i++)
			write_entry(OP_GRID, i, $urandom());

		// Directed words at the reset counts of two and two.
		query(32'd0, 32'd0);
		query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		query(sb.tknot[1], sb.sknot[0]);
		query(sb.tknot[0] + 1, sb.sknot[1] - 1);

		// Full counts, then the extremes of both axes and exact knots.
		set_counts(7'd16, 7'd64);
		query(32'd0, 32'hFFFF_FFFF);
		query(32'hFFFF_FFFF, 32'd0);
		query(sb.tknot[7], sb.sknot[31]);
		query(sb.tknot[15], sb.sknot[63]);
		// Writes beyond the stores are dropped, including all-ones values.
		write_entry(OP_TIME_KNOT, 10'd16, 32'hFFFF_FFFF);
		write_entry(OP_TIME_KNOT, 10'd1023, 32'd0);
		write_entry(OP_SPOT_KNOT, 10'd64, 32'hFFFF_FFFF);
		write_entry(OP_SPOT_KNOT, 10'd1023, 32'd0);
		query(sb.tknot[3] + 5, sb.sknot[5] + 5);
		// Equal neighboring knots give a zero weight.
		write_entry(OP_TIME_KNOT, 10'd1, sb.tknot[0]);
		query(sb.tknot[0] + 1, sb.sknot[10] + 1);
		// An out-of-order spot knot gives a negative ratio, clamped to zero,
		// and a first knot above the last exercises the inverted clamp.
		write_entry(OP_SPOT_KNOT, 10'd2, 32'd0);
		query(sb.tknot[4] + 7, sb.sknot[1] + 3);
		write_entry(OP_SPOT_KNOT, 10'd63, 32'd1);
		query(sb.tknot[9], 32'h8000_0000);
		query(sb.tknot[9], 32'd0);

		// Random phases through many count settings, extremes and out of range
		// values among them. Odd phases run with no idling on either side.
		for (int ph = 0; ph < 8; ph++) begin
			automatic bit [6:0] tsel[8] = '{7'd0, 7'd16, 7'd1, 7'd31, 7'd5, 7'd2, 7'h62, 7'd9};
			automatic bit [6:0] ssel[8] = '{7'd127, 7'd2, 7'd1, 7'd64, 7'd0, 7'd65, 7'd33, 7'd7};
			calm = ph[0];
			set_counts(tsel[ph], ssel[ph]);
			if (ph == 2 || ph == 5) lay_knots();
			for (int k = 0; k < 70; k++) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 72) query(pick_coord(1'b0), pick_coord(1'b1));
				else if (r < 92) write_entry(OP_GRID, $urandom(), $urandom());
				else if (r < 96) write_entry(OP_TIME_KNOT, $urandom(), $urandom());
				else write_entry(OP_SPOT_KNOT, $urandom(), $urandom());
			end
		end

		req_ch.valid = 1'b0;
		wait (sb.pending_vol.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d table writes and %0d queries over %0d count settings.",
			n_writes, n_queries, n_settings);
		$display("Checked %0d volatility words, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_vol.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Hard limit, far above the slowest correct run.
	initial begin
		#(12 * 3000000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
